[hw/rtl/att_pkg.sv]
package att_pkg;

  localparam int unsigned COLS     = 80;
  localparam int unsigned ROWS     = 25;
  localparam int unsigned CELLS    = COLS * ROWS;
  localparam int unsigned MAXP     = 8;
  localparam int unsigned TAB      = 8;
  localparam int unsigned ADDR_W   = 11;
  localparam int unsigned ROW_W    = 5;
  localparam int unsigned COL_W    = 7;
  localparam int unsigned PCNT_W   = $clog2(MAXP + 1);
  localparam int unsigned PIDX_W   = (MAXP > 1) ? $clog2(MAXP) : 1;
  localparam int unsigned QDEPTH   = 2;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SGR   = 8'h6D;
  localparam logic [7:0] CH_HOME  = 8'h48;
  localparam logic [7:0] CH_CLEAR = 8'h4A;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] FIN_LO   = 8'h40;
  localparam logic [7:0] FIN_HI   = 8'h7E;
  localparam logic [7:0] DIG_LO   = 8'h30;
  localparam logic [7:0] DIG_HI   = 8'h39;

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_SEEN = 2'd1;
  localparam logic [1:0] ESC_CSI  = 2'd2;

  typedef enum logic [3:0] {
    CL_READ, CL_ESC, CL_LBRK, CL_DIGIT, CL_SEMI, CL_SGR, CL_HOME, CL_CLEAR,
    CL_FINAL, CL_LF, CL_CR, CL_BS, CL_TAB, CL_OTHER
  } cls_e;

  typedef struct packed {
    cls_e              cls;
    logic [7:0]        char_code;
    logic [ADDR_W-1:0] addr;
  } item_t;

  function automatic logic [2:0] colour_map(input logic [2:0] c);
    case (c)
      3'd0: colour_map = 3'd0;
      3'd1: colour_map = 3'd4;
      3'd2: colour_map = 3'd2;
      3'd3: colour_map = 3'd6;
      3'd4: colour_map = 3'd1;
      3'd5: colour_map = 3'd5;
      3'd6: colour_map = 3'd3;
      default: colour_map = 3'd7;
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] cell_idx(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
    cell_idx = ADDR_W'(ADDR_W'(r) * ADDR_W'(COLS) + ADDR_W'(c));
  endfunction

endpackage

[hw/rtl/att_front.sv]
module att_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        busy_i,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic                        action_i,
  input  logic [7:0]                  char_code_i,
  input  logic [att_pkg::ADDR_W-1:0]  cell_address_i,
  output logic                        valid_o,
  output att_pkg::item_t              item_o,
  input  logic                        pop_i
);

  att_pkg::item_t ent_q [att_pkg::QDEPTH];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q;
  att_pkg::cls_e  cls;
  logic           do_push, do_pop;

  always_comb begin
    if (action_i) begin
      cls = att_pkg::CL_READ;
    end else if (char_code_i == att_pkg::CH_ESC) begin
      cls = att_pkg::CL_ESC;
    end else if (char_code_i == att_pkg::CH_LBRK) begin
      cls = att_pkg::CL_LBRK;
    end else if (char_code_i >= att_pkg::DIG_LO && char_code_i <= att_pkg::DIG_HI) begin
      cls = att_pkg::CL_DIGIT;
    end else if (char_code_i == att_pkg::CH_SEMI) begin
      cls = att_pkg::CL_SEMI;
    end else if (char_code_i == att_pkg::CH_SGR) begin
      cls = att_pkg::CL_SGR;
    end else if (char_code_i == att_pkg::CH_HOME) begin
      cls = att_pkg::CL_HOME;
    end else if (char_code_i == att_pkg::CH_CLEAR) begin
      cls = att_pkg::CL_CLEAR;
    end else if (char_code_i >= att_pkg::FIN_LO && char_code_i <= att_pkg::FIN_HI) begin
      cls = att_pkg::CL_FINAL;
    end else if (char_code_i == att_pkg::CH_LF) begin
      cls = att_pkg::CL_LF;
    end else if (char_code_i == att_pkg::CH_CR) begin
      cls = att_pkg::CL_CR;
    end else if (char_code_i == att_pkg::CH_BS) begin
      cls = att_pkg::CL_BS;
    end else if (char_code_i == att_pkg::CH_TAB) begin
      cls = att_pkg::CL_TAB;
    end else begin
      cls = att_pkg::CL_OTHER;
    end
  end

  assign full_o  = busy_i || (cnt_q == 2'(att_pkg::QDEPTH));
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = ent_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wptr_q] <= '{cls: cls, char_code: char_code_i, addr: cell_address_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

[hw/rtl/att_back.sv]
module att_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  output logic                        busy_o,
  input  logic                        valid_i,
  input  att_pkg::item_t              item_i,
  output logic                        pop_o,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [att_pkg::ROW_W-1:0]   cursor_row_o,
  output logic [att_pkg::COL_W-1:0]   cursor_col_o,
  output logic [att_pkg::ADDR_W-1:0]  cursor_position_o,
  output logic [15:0]                 cell_data_o,
  output logic [7:0]                  current_attr_o
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_TAB  = 3'd2;
  localparam logic [2:0] S_SCRL = 3'd3;
  localparam logic [2:0] S_SBLK = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;

  localparam logic [att_pkg::ADDR_W-1:0] LAST_CELL = att_pkg::ADDR_W'(att_pkg::CELLS - 1);
  localparam logic [att_pkg::ADDR_W-1:0] MOVE_END  =
    att_pkg::ADDR_W'(att_pkg::CELLS - att_pkg::COLS);
  localparam logic [att_pkg::ADDR_W-1:0] COLS_A    = att_pkg::ADDR_W'(att_pkg::COLS);
  localparam logic [att_pkg::COL_W-1:0]  LAST_COL  = att_pkg::COL_W'(att_pkg::COLS - 1);
  localparam logic [att_pkg::ROW_W-1:0]  LAST_ROW  = att_pkg::ROW_W'(att_pkg::ROWS - 1);

  logic [15:0] mem_q [att_pkg::CELLS];
  logic [15:0] rdata_q;
  logic        we, re;
  logic [att_pkg::ADDR_W-1:0] waddr, raddr;
  logic [15:0] wdata;

  logic [2:0]  state_q, state_d;
  logic [att_pkg::ADDR_W-1:0] cnt_q, cnt_d;
  logic        init_q, init_d;
  logic [att_pkg::ROW_W:0]   row_q, row_d;
  logic [att_pkg::COL_W-1:0] col_q, col_d, tab_end_q, tab_end_d;
  logic [1:0]  esc_q, esc_d;
  logic [7:0]  par_q [att_pkg::MAXP];
  logic [7:0]  par_d [att_pkg::MAXP];
  logic [att_pkg::PCNT_W-1:0] pcnt_q, pcnt_d;
  logic [2:0]  fg_q, fg_d, bg_q, bg_d;
  logic        br_q, br_d;
  logic [7:0]  attr_q, attr_d;
  logic        oor_q, oor_d;

  logic        out_valid_q;
  logic        out_ld;
  logic [15:0] out_data;
  logic [15:0] blank;
  logic [att_pkg::ADDR_W-1:0] cur_idx;
  logic [att_pkg::COL_W:0]    col_inc;
  logic [att_pkg::COL_W:0]    tab_next;
  logic [att_pkg::PCNT_W-1:0] pc_open;
  logic [11:0] acc;
  logic [2:0]  sfg, sbg;
  logic        sbr;

  assign blank   = {attr_q, att_pkg::CH_SPACE};
  assign cur_idx = att_pkg::cell_idx(row_q[att_pkg::ROW_W-1:0], col_q);
  assign col_inc = {1'b0, col_q} + 1'b1;
  assign busy_o  = init_q;
  assign empty_o = !out_valid_q;
  assign pc_open = (pcnt_q == '0) ? att_pkg::PCNT_W'(1) : pcnt_q;
  assign acc     = 12'(par_q[att_pkg::PIDX_W'(pc_open - 1'b1)]) * 12'd10
                 + 12'(item_i.char_code - att_pkg::DIG_LO);

  always_comb begin
    tab_next = (att_pkg::COL_W+1)'(((col_q / att_pkg::TAB) + 1) * att_pkg::TAB);
    if (tab_next > {1'b0, LAST_COL}) tab_next = {1'b0, LAST_COL};
  end

  // SGR parameters act in order; a zero restores the defaults
  always_comb begin
    sfg = fg_q;
    sbg = bg_q;
    sbr = br_q;
    if (pcnt_q == '0) begin
      sfg = 3'd7; sbg = 3'd0; sbr = 1'b0;
    end else begin
      for (int i = 0; i < att_pkg::MAXP; i++) begin
        if (att_pkg::PCNT_W'(i) < pcnt_q) begin
          if (par_q[i] == 8'd0) begin
            sfg = 3'd7; sbg = 3'd0; sbr = 1'b0;
          end else if (par_q[i] == 8'd1) begin
            sbr = 1'b1;
          end else if (par_q[i] >= 8'd30 && par_q[i] <= 8'd37) begin
            sfg = 3'(par_q[i] - 8'd30);
          end else if (par_q[i] >= 8'd40 && par_q[i] <= 8'd47) begin
            sbg = 3'(par_q[i] - 8'd40);
          end
        end
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    init_d    = init_q;
    row_d     = row_q;
    col_d     = col_q;
    tab_end_d = tab_end_q;
    esc_d     = esc_q;
    par_d     = par_q;
    pcnt_d    = pcnt_q;
    fg_d      = fg_q;
    bg_d      = bg_q;
    br_d      = br_q;
    attr_d    = attr_q;
    oor_d     = oor_q;
    we        = 1'b0;
    waddr     = cur_idx;
    wdata     = blank;
    re        = 1'b0;
    raddr     = item_i.addr;
    pop_o     = 1'b0;
    out_ld    = 1'b0;
    out_data  = 16'h0000;

    case (state_q)
      S_CLR: begin
        we    = 1'b1;
        waddr = cnt_q;
        if (cnt_q == LAST_CELL) begin
          state_d = S_IDLE;
          init_d  = 1'b0;
          out_ld  = !init_q;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (valid_i && !out_valid_q) begin
          pop_o  = 1'b1;
          out_ld = 1'b1;
          if (item_i.cls == att_pkg::CL_READ) begin
            out_ld  = 1'b0;
            re      = (item_i.addr <= LAST_CELL);
            oor_d   = (item_i.addr > LAST_CELL);
            state_d = S_RD;
          end else if (esc_q == att_pkg::ESC_SEEN) begin
            if (item_i.cls == att_pkg::CL_LBRK) begin
              esc_d  = att_pkg::ESC_CSI;
              pcnt_d = '0;
              for (int i = 0; i < att_pkg::MAXP; i++) par_d[i] = 8'd0;
            end else begin
              esc_d = att_pkg::ESC_NONE;
            end
          end else if (esc_q == att_pkg::ESC_CSI) begin
            case (item_i.cls)
              att_pkg::CL_DIGIT: begin
                pcnt_d = pc_open;
                par_d[att_pkg::PIDX_W'(pc_open - 1'b1)] =
                  (acc > 12'd255) ? 8'd255 : acc[7:0];
              end
              att_pkg::CL_SEMI: begin
                if (pcnt_q < att_pkg::PCNT_W'(att_pkg::MAXP)) pcnt_d = pcnt_q + 1'b1;
              end
              att_pkg::CL_SGR: begin
                fg_d   = sfg;
                bg_d   = sbg;
                br_d   = sbr;
                attr_d = {1'b0, att_pkg::colour_map(sbg), sbr, att_pkg::colour_map(sfg)};
                esc_d  = att_pkg::ESC_NONE;
              end
              att_pkg::CL_HOME: begin
                row_d = '0;
                col_d = '0;
                esc_d = att_pkg::ESC_NONE;
              end
              att_pkg::CL_CLEAR: begin
                out_ld  = 1'b0;
                row_d   = '0;
                col_d   = '0;
                esc_d   = att_pkg::ESC_NONE;
                cnt_d   = '0;
                state_d = S_CLR;
              end
              att_pkg::CL_FINAL, att_pkg::CL_LBRK: begin
                esc_d = att_pkg::ESC_NONE;
              end
              default: begin
              end
            endcase
          end else if (esc_q != att_pkg::ESC_NONE) begin
            esc_d = att_pkg::ESC_NONE;
          end else begin
            case (item_i.cls)
              att_pkg::CL_ESC: esc_d = att_pkg::ESC_SEEN;
              att_pkg::CL_LF: begin
                col_d = '0;
                row_d = row_q + 1'b1;
              end
              att_pkg::CL_CR: col_d = '0;
              att_pkg::CL_BS: begin
                if (col_q != '0) begin
                  col_d = col_q - 1'b1;
                  we    = 1'b1;
                  waddr = cur_idx - 1'b1;
                end else if (row_q != '0) begin
                  row_d = row_q - 1'b1;
                  col_d = LAST_COL;
                  we    = 1'b1;
                  waddr = cur_idx - 1'b1;
                end
              end
              att_pkg::CL_TAB: begin
                out_ld    = 1'b0;
                tab_end_d = tab_next[att_pkg::COL_W-1:0];
                state_d   = S_TAB;
              end
              default: begin
                we    = 1'b1;
                wdata = {attr_q, item_i.char_code};
                if (col_inc >= (att_pkg::COL_W+1)'(att_pkg::COLS)) begin
                  col_d = '0;
                  row_d = row_q + 1'b1;
                end else begin
                  col_d = col_inc[att_pkg::COL_W-1:0];
                end
              end
            endcase
          end
          // leaving the bottom row starts the scroll
          if (row_d >= (att_pkg::ROW_W+1)'(att_pkg::ROWS)) begin
            out_ld  = 1'b0;
            cnt_d   = '0;
            state_d = S_SCRL;
          end
        end
      end
      S_TAB: begin
        if (col_q < tab_end_q) begin
          we    = 1'b1;
          col_d = col_q + 1'b1;
        end else begin
          out_ld  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SCRL: begin
        re    = (cnt_q != MOVE_END);
        raddr = cnt_q + COLS_A;
        we    = (cnt_q != '0);
        waddr = cnt_q - 1'b1;
        wdata = rdata_q;
        if (cnt_q == MOVE_END) begin
          state_d = S_SBLK;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_SBLK: begin
        we    = 1'b1;
        waddr = cnt_q;
        if (cnt_q == LAST_CELL) begin
          row_d   = {1'b0, LAST_ROW};
          col_d   = '0;
          out_ld  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_RD: begin
        out_ld   = 1'b1;
        out_data = oor_q ? 16'h0000 : rdata_q;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      cursor_row_o      <= row_d[att_pkg::ROW_W-1:0];
      cursor_col_o      <= col_d;
      cursor_position_o <= att_pkg::cell_idx(row_d[att_pkg::ROW_W-1:0], col_d);
      cell_data_o       <= out_data;
      current_attr_o    <= attr_d;
    end
    tab_end_q <= tab_end_d;
    oor_q     <= oor_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      cnt_q       <= '0;
      init_q      <= 1'b1;
      row_q       <= '0;
      col_q       <= '0;
      esc_q       <= att_pkg::ESC_NONE;
      for (int i = 0; i < att_pkg::MAXP; i++) par_q[i] <= 8'd0;
      pcnt_q      <= '0;
      fg_q        <= 3'd7;
      bg_q        <= 3'd0;
      br_q        <= 1'b0;
      attr_q      <= 8'h07;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      init_q  <= init_d;
      row_q   <= row_d;
      col_q   <= col_d;
      esc_q   <= esc_d;
      par_q   <= par_d;
      pcnt_q  <= pcnt_d;
      fg_q    <= fg_d;
      bg_q    <= bg_d;
      br_q    <= br_d;
      attr_q  <= attr_d;
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/ansi_text_terminal_unit.sv]
// Text terminal engine with an 80x25 cell store.
// Input queue: present action_i, char_code_i and cell_address_i with
// push; the item is taken on a clock edge where full is low. A put
// (action 0) feeds one byte to the ESC/CSI parser or prints it; a read
// (action 1) fetches one cell.
// Result register: while empty is low the result is on the output
// ports; pop takes it. Every item gives exactly one result.
// A put loads its result into the output registers; a read first latches
// the cell from the store, then loads it. A tab blanks cells up to the
// next tab stop. A scroll moves rows up through the store, then blanks
// the last row; a clear screen writes one cell per cycle.
// The back end takes a new item only once the last result was popped.
// A two-entry input queue lets bytes arrive while the back end works.
// Reset: a fill pass writes 0x0720 into all 2000 cells, one per cycle;
// full stays high until the fill pass ends.
// Stall: while a result waits unpopped the back end holds the next item;
// the input queue keeps taking items until it is full.
module ansi_text_terminal_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic                        action_i,
  input  logic [7:0]                  char_code_i,
  input  logic [att_pkg::ADDR_W-1:0]  cell_address_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [att_pkg::ROW_W-1:0]   cursor_row_o,
  output logic [att_pkg::COL_W-1:0]   cursor_col_o,
  output logic [att_pkg::ADDR_W-1:0]  cursor_position_o,
  output logic [15:0]                 cell_data_o,
  output logic [7:0]                  current_attr_o
);

  logic           busy, q_valid, q_pop;
  att_pkg::item_t q_item;

  att_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .busy_i         (busy),
    .push_i         (push),
    .full_o         (full),
    .action_i       (action_i),
    .char_code_i    (char_code_i),
    .cell_address_i (cell_address_i),
    .valid_o        (q_valid),
    .item_o         (q_item),
    .pop_i          (q_pop)
  );

  att_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .busy_o            (busy),
    .valid_i           (q_valid),
    .item_i            (q_item),
    .pop_o             (q_pop),
    .empty_o           (empty),
    .pop_i             (pop),
    .cursor_row_o      (cursor_row_o),
    .cursor_col_o      (cursor_col_o),
    .cursor_position_o (cursor_position_o),
    .cell_data_o       (cell_data_o),
    .current_attr_o    (current_attr_o)
  );

`ifndef ASSERT_OFF
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (cursor_col_o < att_pkg::COL_W'(att_pkg::COLS)))
    else $error("cursor column out of range");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (cursor_row_o < att_pkg::ROW_W'(att_pkg::ROWS)))
    else $error("cursor row out of range");

  a_pos_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (cursor_position_o == att_pkg::cell_idx(cursor_row_o, cursor_col_o)))
    else $error("cursor position mismatch");

  a_fill_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (full && empty))
    else $error("item taken during reset fill");
`endif

endmodule
